[rtl/sadf_pkg.sv]
// package for the slot allocator with deferred release
// sizes, request codes, status codes, config indices and controller states; no dependencies
`default_nettype none
package sadf_pkg;
  localparam int SLOT_COUNT = 1024;
  localparam int PENDING_DEPTH = 256;

  localparam logic [2:0] REQ_INIT = 3'd0;
  localparam logic [2:0] REQ_SHUTDOWN = 3'd1;
  localparam logic [2:0] REQ_ALLOC = 3'd2;
  localparam logic [2:0] REQ_FREE_NOW = 3'd3;
  localparam logic [2:0] REQ_FREE_DEFER = 3'd4;
  localparam logic [2:0] REQ_ADVANCE = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_EFFECT = 3'd1;
  localparam logic [2:0] ST_NOT_INIT = 3'd2;
  localparam logic [2:0] ST_OUT_OF_SLOTS = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;
  localparam logic [2:0] ST_PENDING_FULL = 3'd5;

  localparam logic [2:0] CFG_CAPACITY = 3'd0;
  localparam logic [2:0] CFG_DELAY = 3'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_CLEAR, S_ALLOC_RD, S_ALLOC_WR, S_FREE_RD, S_FREE_WR,
    S_WALK_RD, S_WALK_CHK, S_WALK_REL, S_DONE
  } state_t;
endpackage
`default_nettype wire

[rtl/slot_allocator_deferred_free.sv]
// top level of the slot allocator with deferred release
// depends on sadf_pkg; holds the free stack, allocated bitmap and pending memories
//
// usage: a request enters on the in_ channel (tdata = req_type, slot_index, frame_index
// from the lowest bit up) and one result leaves on the out_ channel. one request is
// worked at a time; in_tready is low from acceptance until the result is taken.
// a request that is refused or has no effect goes straight to the result; allocate,
// free now and free deferred pass through memory read, modify and result, and
// advance frame does a pending read and a compare per pending entry and a release
// through the bitmap memory per released entry. init clears the allocated bitmap
// one entry a cycle, then fills the free stack one entry a cycle; shutdown clears
// the bitmap. the next request is accepted only once the result has been taken.
// after reset the bitmap is cleared once while no request is accepted. a stalled
// receiver holds out_tvalid and the result register; no new request is taken
// meanwhile.
// configuration writes on cfg_ take effect at the next init.
`default_nettype none
module slot_allocator_deferred_free (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // req_type[2:0], slot_index[14:3], frame_index[46:15], zero fill
  input  wire  [47:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // status[2:0], granted_slot[12:3], released_count[21:13], free_count[32:22],
  // is_ready[33], zero fill
  output logic [39:0] out_tdata,
  input  wire         cfg_wr_en,
  input  wire  [2:0]  cfg_index,
  input  wire  [10:0] cfg_data
);
  localparam int SLOT_COUNT = sadf_pkg::SLOT_COUNT;
  localparam int PENDING_DEPTH = sadf_pkg::PENDING_DEPTH;
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int QW = $clog2(PENDING_DEPTH + 1);

  // memories
  logic [SW-1:0] stack_mem [SLOT_COUNT];
  logic          map_mem   [SLOT_COUNT];
  logic [SW-1:0] pslot_mem [PENDING_DEPTH];
  logic [32:0]   pdue_mem  [PENDING_DEPTH];

  sadf_pkg::state_t state_r, state_nxt;
  logic [10:0] cap_cfg_r, cap_cfg_nxt;
  logic [7:0]  dly_cfg_r, dly_cfg_nxt;
  logic [CW-1:0] top_r, top_nxt, lcap_r, lcap_nxt;
  logic [7:0]  ldly_r, ldly_nxt;
  logic [QW-1:0] pcnt_r, pcnt_nxt, rd_r, rd_nxt, kept_r, kept_nxt;
  logic [31:0] frame_r, frame_nxt;
  logic        ready_r, ready_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        clr_then_fill_r, clr_then_fill_nxt;
  logic [2:0]  req_r, req_nxt;
  logic [11:0] slot_r, slot_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [SW-1:0] gr_r, gr_nxt;
  logic [8:0]  rel_r, rel_nxt;
  logic        ov_r, ov_nxt;
  logic [39:0] out_r, out_nxt;

  // memory ports
  logic          stk_we;  logic [SW-1:0] stk_wa, stk_wd, stk_ra, stk_q;
  logic          map_we;  logic [SW-1:0] map_wa, map_ra; logic map_wd, map_q;
  logic          pnd_we;  logic [PW-1:0] pnd_wa, pnd_ra;
  logic [SW-1:0] pnd_ws, pnd_qs; logic [32:0] pnd_wf, pnd_qf;

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_q <= stack_mem[stk_ra];
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[map_ra];
    if (pnd_we) begin
      pslot_mem[pnd_wa] <= pnd_ws;
      pdue_mem[pnd_wa]  <= pnd_wf;
    end
    pnd_qs <= pslot_mem[pnd_ra];
    pnd_qf <= pdue_mem[pnd_ra];
  end

  wire [2:0]  in_req   = in_tdata[2:0];
  wire [11:0] in_slot  = in_tdata[14:3];
  wire [31:0] in_frame = in_tdata[46:15];
  wire        in_acc   = in_tvalid && in_tready;
  wire        slot_in_range = slot_r < 12'(lcap_r);

  assign in_tready  = (state_r == sadf_pkg::S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  always_comb begin
    cap_cfg_nxt = cap_cfg_r;
    dly_cfg_nxt = dly_cfg_r;
    if (cfg_wr_en && cfg_index == sadf_pkg::CFG_CAPACITY) cap_cfg_nxt = cfg_data;
    if (cfg_wr_en && cfg_index == sadf_pkg::CFG_DELAY) dly_cfg_nxt = cfg_data[7:0];
  end

  // next state and datapath
  always_comb begin
    logic [11:0] capv;
    state_nxt = state_r;
    top_nxt = top_r; lcap_nxt = lcap_r; ldly_nxt = ldly_r; pcnt_nxt = pcnt_r;
    rd_nxt = rd_r; kept_nxt = kept_r; frame_nxt = frame_r; ready_nxt = ready_r;
    cnt_nxt = cnt_r; clr_then_fill_nxt = clr_then_fill_r;
    req_nxt = req_r; slot_nxt = slot_r; st_nxt = st_r; gr_nxt = gr_r; rel_nxt = rel_r;
    ov_nxt = ov_r; out_nxt = out_r;
    stk_we = 1'b0; stk_wa = top_r[SW-1:0]; stk_wd = '0;
    stk_ra = SW'(top_r - CW'(1));
    map_we = 1'b0; map_wa = slot_r[SW-1:0]; map_wd = 1'b0; map_ra = slot_r[SW-1:0];
    pnd_we = 1'b0; pnd_wa = pcnt_r[PW-1:0]; pnd_ws = slot_r[SW-1:0];
    pnd_wf = {1'b0, frame_r} + 33'(ldly_r);
    pnd_ra = rd_r[PW-1:0];
    capv = (cap_cfg_r > 11'(SLOT_COUNT)) ? 12'(SLOT_COUNT) : {1'b0, cap_cfg_r};
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      sadf_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_req; slot_nxt = in_slot; gr_nxt = '0; rel_nxt = '0;
          st_nxt = sadf_pkg::ST_NO_EFFECT;
          state_nxt = sadf_pkg::S_DONE;
          case (in_req) inside
            sadf_pkg::REQ_INIT: begin
              if (!ready_r && cap_cfg_r == '0) st_nxt = sadf_pkg::ST_OUT_OF_SLOTS;
              else if (!ready_r) begin
                st_nxt = sadf_pkg::ST_OK;
                lcap_nxt = CW'(capv); ldly_nxt = dly_cfg_r; top_nxt = '0;
                pcnt_nxt = '0; frame_nxt = '0; ready_nxt = 1'b1;
                cnt_nxt = '0; clr_then_fill_nxt = 1'b1;
                state_nxt = sadf_pkg::S_CLEAR;
              end
            end
            sadf_pkg::REQ_SHUTDOWN: begin
              if (ready_r) begin
                st_nxt = sadf_pkg::ST_OK;
                top_nxt = '0; pcnt_nxt = '0; frame_nxt = '0; ready_nxt = 1'b0;
                lcap_nxt = '0; ldly_nxt = 8'd3; cnt_nxt = '0;
                clr_then_fill_nxt = 1'b0;
                state_nxt = sadf_pkg::S_CLEAR;
              end
            end
            sadf_pkg::REQ_ALLOC: begin
              if (!ready_r) st_nxt = sadf_pkg::ST_NOT_INIT;
              else if (top_r == '0) st_nxt = sadf_pkg::ST_OUT_OF_SLOTS;
              else state_nxt = sadf_pkg::S_ALLOC_RD;
            end
            sadf_pkg::REQ_FREE_NOW, sadf_pkg::REQ_FREE_DEFER: begin
              if (!ready_r) st_nxt = sadf_pkg::ST_NOT_INIT;
              else state_nxt = sadf_pkg::S_FREE_RD;
            end
            sadf_pkg::REQ_ADVANCE: begin
              frame_nxt = in_frame;
              if (!ready_r) st_nxt = sadf_pkg::ST_NOT_INIT;
              else begin
                st_nxt = sadf_pkg::ST_OK; rd_nxt = '0; kept_nxt = '0;
                state_nxt = sadf_pkg::S_WALK_RD;
              end
            end
            default: st_nxt = sadf_pkg::ST_NO_EFFECT;
          endcase
        end
      end
      sadf_pkg::S_CLEAR: begin
        map_we = 1'b1; map_wa = cnt_r[SW-1:0]; map_wd = 1'b0;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SLOT_COUNT - 1)) begin
          cnt_nxt = '0;
          state_nxt = clr_then_fill_r ? sadf_pkg::S_FILL :
                      (req_r == sadf_pkg::REQ_SHUTDOWN ? sadf_pkg::S_DONE : sadf_pkg::S_IDLE);
        end
      end
      sadf_pkg::S_FILL: begin
        stk_we = 1'b1; stk_wa = cnt_r[SW-1:0];
        stk_wd = SW'(lcap_r - CW'(1) - cnt_r);
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r + CW'(1) == lcap_r) begin
          top_nxt = lcap_r; state_nxt = sadf_pkg::S_DONE;
        end
      end
      sadf_pkg::S_ALLOC_RD: state_nxt = sadf_pkg::S_ALLOC_WR;
      sadf_pkg::S_ALLOC_WR: begin
        top_nxt = top_r - CW'(1);
        gr_nxt = stk_q; st_nxt = sadf_pkg::ST_OK;
        map_we = 1'b1; map_wa = stk_q; map_wd = 1'b1;
        state_nxt = sadf_pkg::S_DONE;
      end
      sadf_pkg::S_FREE_RD: begin
        if (!slot_in_range) begin
          st_nxt = sadf_pkg::ST_RANGE; state_nxt = sadf_pkg::S_DONE;
        end else state_nxt = sadf_pkg::S_FREE_WR;
      end
      sadf_pkg::S_FREE_WR: begin
        state_nxt = sadf_pkg::S_DONE;
        if (!map_q) st_nxt = sadf_pkg::ST_NO_EFFECT;
        else if (req_r == sadf_pkg::REQ_FREE_NOW) begin
          st_nxt = sadf_pkg::ST_OK;
          map_we = 1'b1; map_wd = 1'b0;
          stk_we = 1'b1; stk_wd = slot_r[SW-1:0]; top_nxt = top_r + CW'(1);
        end else if (pcnt_r >= QW'(PENDING_DEPTH)) st_nxt = sadf_pkg::ST_PENDING_FULL;
        else begin
          st_nxt = sadf_pkg::ST_OK; pnd_we = 1'b1; pcnt_nxt = pcnt_r + QW'(1);
        end
      end
      sadf_pkg::S_WALK_RD: begin
        if (rd_r == pcnt_r) begin
          pcnt_nxt = kept_r; state_nxt = sadf_pkg::S_DONE;
        end else state_nxt = sadf_pkg::S_WALK_CHK;
      end
      sadf_pkg::S_WALK_CHK: begin
        map_ra = pnd_qs; slot_nxt = 12'(pnd_qs);
        rd_nxt = rd_r + QW'(1);
        if (pnd_qf <= {1'b0, frame_r}) begin
          rel_nxt = rel_r + 9'd1; state_nxt = sadf_pkg::S_WALK_REL;
        end else begin
          pnd_we = 1'b1; pnd_wa = kept_r[PW-1:0]; pnd_ws = pnd_qs; pnd_wf = pnd_qf;
          kept_nxt = kept_r + QW'(1); state_nxt = sadf_pkg::S_WALK_RD;
        end
      end
      sadf_pkg::S_WALK_REL: begin
        if (map_q) begin
          map_we = 1'b1; map_wd = 1'b0;
          stk_we = 1'b1; stk_wd = slot_r[SW-1:0]; top_nxt = top_r + CW'(1);
        end
        state_nxt = sadf_pkg::S_WALK_RD;
      end
      sadf_pkg::S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          out_nxt = {6'd0, ready_r, 11'(top_r), rel_r,
                     10'(gr_r), st_r};
          state_nxt = sadf_pkg::S_IDLE;
        end
      end
      default: state_nxt = sadf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sadf_pkg::S_CLEAR;
      clr_then_fill_r <= 1'b0; req_r <= sadf_pkg::REQ_INIT; cnt_r <= '0;
      cap_cfg_r <= 11'd1024; dly_cfg_r <= 8'd3;
      top_r <= '0; lcap_r <= '0; ldly_r <= 8'd3; pcnt_r <= '0;
      frame_r <= '0; ready_r <= 1'b0; ov_r <= 1'b0;
      rd_r <= '0; kept_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_then_fill_r <= clr_then_fill_nxt; req_r <= req_nxt; cnt_r <= cnt_nxt;
      cap_cfg_r <= cap_cfg_nxt; dly_cfg_r <= dly_cfg_nxt;
      top_r <= top_nxt; lcap_r <= lcap_nxt; ldly_r <= ldly_nxt; pcnt_r <= pcnt_nxt;
      frame_r <= frame_nxt; ready_r <= ready_nxt; ov_r <= ov_nxt;
      rd_r <= rd_nxt; kept_r <= kept_nxt;
    end
    slot_r <= slot_nxt; st_r <= st_nxt; gr_r <= gr_nxt; rel_r <= rel_nxt;
    out_r <= out_nxt;
  end
endmodule
`default_nettype wire
